// File: sv/dps_pkg.sv
// ----------------------------------------------------------------------------
// dps_pkg
// Shared types and constants of the dynamic priority scheduler: slot record,
// result event codes and the control and result groups of the slot picker.
// ----------------------------------------------------------------------------
package dps_pkg;

  localparam int MAX_TASKS = 16;
  localparam int IDX_W     = $clog2(MAX_TASKS);

  typedef logic [IDX_W-1:0] idx_t;

  localparam idx_t LAST_IDX = idx_t'(MAX_TASKS - 1);

  localparam logic signed [7:0] PRIO_MIN = 8'sh80;
  localparam logic [15:0]       RAN_MAX  = 16'hffff;

  typedef enum logic [2:0] {
    EV_ADMIT   = 3'd0,
    EV_REQUEUE = 3'd1,
    EV_FINISH  = 3'd2,
    EV_IDLE    = 3'd3,
    EV_FULL    = 3'd4
  } event_t;

  // one task slot as stored in the slot memory
  typedef struct packed {
    logic [7:0]        task_id;
    logic signed [7:0] prio;
    logic [15:0]       needed;
    logic [15:0]       ran;
    logic [31:0]       stamp;
  } slot_rec_t;

  typedef struct packed {
    logic clear;
    logic cand_en;
    idx_t cand_idx;
  } pick_ctl_t;

  typedef struct packed {
    logic      found;
    idx_t      idx;
    slot_rec_t rec;
  } pick_res_t;

endpackage

// File: sv/dynamic_priority_scheduler.sv
// ----------------------------------------------------------------------------
// dynamic_priority_scheduler
// Task table with dynamic priorities: admits tasks into free slots and, on
// each tick, runs the highest-priority task, then finishes or requeues it.
// ----------------------------------------------------------------------------
//
//  channel   handshake             payload
//  -------   --------------------  ---------------------------------------------
//  input     start & !busy         in_kind, in_task_id, in_start_priority,
//                                  in_needed_ticks
//  result    out_valid (1 cycle)   out_event_res, out_task_id, out_priority,
//                                  out_ran_ticks
//
//  a tick reads every slot once through the single slot memory read port,
//  then updates the picked task's slot in S_WB
//  an admit walks the valid bits one slot a cycle up to the first free one,
//  or through all MAX_TASKS slots on a full table
//  the result strobe comes in the cycle after the last working cycle, while busy
//  is already low, so the next item may be accepted during the strobe
//  reset clears the valid bits and the stamp counter at once: no clearing pass
//  the receiver cannot stall: each result is shown for exactly one cycle
//
module dynamic_priority_scheduler import dps_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  logic              in_kind,
  input  logic [7:0]        in_task_id,
  input  logic signed [7:0] in_start_priority,
  input  logic [15:0]       in_needed_ticks,
  output logic              out_valid,
  output logic [2:0]        out_event_res,
  output logic [7:0]        out_task_id,
  output logic signed [7:0] out_priority,
  output logic [15:0]       out_ran_ticks
);

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_ADMIT = 4'b0010,
    S_SCAN  = 4'b0100,
    S_WB    = 4'b1000
  } state_t;

  state_t state_r, state_nxt;

  // control state
  idx_t                 idx_r, idx_nxt;
  logic [MAX_TASKS-1:0] valid_r, valid_nxt;
  logic [31:0]          stamp_r, stamp_nxt;
  logic                 ov_r, ov_nxt;

  // latched admit item
  logic [7:0]        in_id_r, in_id_nxt;
  logic signed [7:0] in_prio_r, in_prio_nxt;
  logic [15:0]       in_need_r, in_need_nxt;

  // result registers
  event_t            ev_r, ev_nxt;
  logic [7:0]        oid_r, oid_nxt;
  logic signed [7:0] oprio_r, oprio_nxt;
  logic [15:0]       oran_r, oran_nxt;

  // slot memory and picker
  logic      wr_en;
  idx_t      wr_addr;
  slot_rec_t wr_rec;
  slot_rec_t rd_rec;
  pick_ctl_t pick_ctl;
  pick_res_t best;

  // write-back arithmetic for the picked task
  logic [15:0]       ran_inc;
  logic [15:0]       need_eff;
  logic              finish;
  logic signed [7:0] prio_dec;

  dps_slot_ram u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_rec  (wr_rec),
    .rd_addr (idx_nxt),
    .rd_rec  (rd_rec)
  );

  dps_pick u_pick (
    .clk        (clk),
    .rst_n      (rst_n),
    .ctl        (pick_ctl),
    .cand_rec   (rd_rec),
    .next_stamp (stamp_r),
    .best       (best)
  );

  // run count saturates, zero needed time counts as one tick
  assign ran_inc  = (best.rec.ran == RAN_MAX) ? best.rec.ran : best.rec.ran + 16'd1;
  assign need_eff = (best.rec.needed == 16'd0) ? 16'd1 : best.rec.needed;
  assign finish   = (ran_inc >= need_eff);
  assign prio_dec = (best.rec.prio == PRIO_MIN) ? best.rec.prio : best.rec.prio - 8'sd1;

  always_comb begin
    state_nxt   = state_r;
    idx_nxt     = idx_r;
    valid_nxt   = valid_r;
    stamp_nxt   = stamp_r;
    ov_nxt      = 1'b0;
    in_id_nxt   = in_id_r;
    in_prio_nxt = in_prio_r;
    in_need_nxt = in_need_r;
    ev_nxt      = ev_r;
    oid_nxt     = oid_r;
    oprio_nxt   = oprio_r;
    oran_nxt    = oran_r;
    wr_en       = 1'b0;
    wr_addr     = best.idx;
    wr_rec      = best.rec;
    pick_ctl    = '0;

    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          // memory read of slot 0 goes out with the accept
          idx_nxt        = '0;
          in_id_nxt      = in_task_id;
          in_prio_nxt    = in_start_priority;
          in_need_nxt    = in_needed_ticks;
          pick_ctl.clear = 1'b1;
          state_nxt      = in_kind ? S_SCAN : S_ADMIT;
        end
      end

      S_ADMIT: begin
        if (!valid_r[idx_r]) begin
          // lowest free slot takes the task
          valid_nxt[idx_r] = 1'b1;
          wr_en            = 1'b1;
          wr_addr          = idx_r;
          wr_rec.task_id   = in_id_r;
          wr_rec.prio      = in_prio_r;
          wr_rec.needed    = in_need_r;
          wr_rec.ran       = 16'd0;
          wr_rec.stamp     = stamp_r;
          stamp_nxt        = stamp_r + 32'd1;
          ov_nxt           = 1'b1;
          ev_nxt           = EV_ADMIT;
          oid_nxt          = in_id_r;
          oprio_nxt        = in_prio_r;
          oran_nxt         = 16'd0;
          state_nxt        = S_IDLE;
        end else if (idx_r == LAST_IDX) begin
          // table full, nothing stored
          ov_nxt    = 1'b1;
          ev_nxt    = EV_FULL;
          oid_nxt   = in_id_r;
          oprio_nxt = in_prio_r;
          oran_nxt  = 16'd0;
          state_nxt = S_IDLE;
        end else begin
          idx_nxt = idx_t'(idx_r + 1'b1);
        end
      end

      S_SCAN: begin
        // read data of slot idx_r is here; the next slot is read meanwhile
        pick_ctl.cand_en  = valid_r[idx_r];
        pick_ctl.cand_idx = idx_r;
        if (idx_r == LAST_IDX) begin
          state_nxt = S_WB;
        end else begin
          idx_nxt = idx_t'(idx_r + 1'b1);
        end
      end

      S_WB: begin
        ov_nxt    = 1'b1;
        state_nxt = S_IDLE;
        if (!best.found) begin
          ev_nxt    = EV_IDLE;
          oid_nxt   = 8'd0;
          oprio_nxt = 8'sd0;
          oran_nxt  = 16'd0;
        end else if (finish) begin
          // slot freed, priority kept as it was
          valid_nxt[best.idx] = 1'b0;
          ev_nxt              = EV_FINISH;
          oid_nxt             = best.rec.task_id;
          oprio_nxt           = best.rec.prio;
          oran_nxt            = ran_inc;
        end else begin
          // requeue behind equals with a fresh stamp
          wr_en        = 1'b1;
          wr_addr      = best.idx;
          wr_rec.prio  = prio_dec;
          wr_rec.ran   = ran_inc;
          wr_rec.stamp = stamp_r;
          stamp_nxt    = stamp_r + 32'd1;
          ev_nxt       = EV_REQUEUE;
          oid_nxt      = best.rec.task_id;
          oprio_nxt    = prio_dec;
          oran_nxt     = ran_inc;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      idx_r   <= '0;
      valid_r <= '0;
      stamp_r <= 32'd0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      idx_r   <= idx_nxt;
      valid_r <= valid_nxt;
      stamp_r <= stamp_nxt;
      ov_r    <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    in_id_r   <= in_id_nxt;
    in_prio_r <= in_prio_nxt;
    in_need_r <= in_need_nxt;
    ev_r      <= ev_nxt;
    oid_r     <= oid_nxt;
    oprio_r   <= oprio_nxt;
    oran_r    <= oran_nxt;
  end

  assign busy          = (state_r != S_IDLE);
  assign out_valid     = ov_r;
  assign out_event_res = ev_r;
  assign out_task_id   = oid_r;
  assign out_priority  = oprio_r;
  assign out_ran_ticks = oran_r;

  // an accepted item keeps the block busy in the next cycle
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("accepted item did not make the block busy");

  // a result strobe comes with the return to idle and never twice in a row
  a_strobe_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (state_r == S_IDLE))
    else $error("result strobe while still working");

  a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe held for two cycles");

  // an admit takes one stamp and fills one slot
  a_admit_stamp: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_event_res == EV_ADMIT)) |->
      ((stamp_r == $past(stamp_r) + 32'd1)
       && ($countones(valid_r) == $countones($past(valid_r)) + 1)))
    else $error("admit did not take a stamp and a slot");

  // a finish frees exactly one slot and takes no stamp
  a_finish_free: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_event_res == EV_FINISH)) |->
      (($countones(valid_r) == $countones($past(valid_r)) - 1)
       && (stamp_r == $past(stamp_r))))
    else $error("finish did not free exactly one slot");

endmodule

// File: sv/dps_slot_ram.sv
// ----------------------------------------------------------------------------
// dps_slot_ram
// Slot record memory: one write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module dps_slot_ram import dps_pkg::*; (
  input  logic      clk,
  input  logic      wr_en,
  input  idx_t      wr_addr,
  input  slot_rec_t wr_rec,
  input  idx_t      rd_addr,
  output slot_rec_t rd_rec
);

  slot_rec_t mem [MAX_TASKS];
  slot_rec_t rd_rec_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_rec;
    end
    rd_rec_r <= mem[rd_addr];
  end

  assign rd_rec = rd_rec_r;

endmodule

// File: sv/dps_pick.sv
// ----------------------------------------------------------------------------
// dps_pick
// Best-so-far tracker for the slot scan: highest priority wins, oldest stamp
// breaks ties among equal priorities.
// ----------------------------------------------------------------------------
module dps_pick import dps_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  pick_ctl_t   ctl,
  input  slot_rec_t   cand_rec,
  input  logic [31:0] next_stamp,
  output pick_res_t   best
);

  logic        found_r, found_nxt;
  idx_t        idx_r, idx_nxt;
  slot_rec_t   rec_r, rec_nxt;
  logic [31:0] age_r, age_nxt;
  logic [31:0] cand_age;
  logic        better;

  // age modulo 2^32 keeps the order across stamp wrap
  assign cand_age = next_stamp - cand_rec.stamp;

  assign better = !found_r
               || ($signed(cand_rec.prio) > $signed(rec_r.prio))
               || ((cand_rec.prio == rec_r.prio) && (cand_age > age_r));

  always_comb begin
    found_nxt = found_r;
    idx_nxt   = idx_r;
    rec_nxt   = rec_r;
    age_nxt   = age_r;
    if (ctl.clear) begin
      found_nxt = 1'b0;
    end else if (ctl.cand_en && better) begin
      found_nxt = 1'b1;
      idx_nxt   = ctl.cand_idx;
      rec_nxt   = cand_rec;
      age_nxt   = cand_age;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      found_r <= 1'b0;
    end else begin
      found_r <= found_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r <= idx_nxt;
    rec_r <= rec_nxt;
    age_r <= age_nxt;
  end

  assign best.found = found_r;
  assign best.idx   = idx_r;
  assign best.rec   = rec_r;

endmodule
